// ----- rtl/core/sfcp_pkg.sv -----
// sfcp_pkg: shared types and constants for the framed command parser.
// Used by sync_framed_command_parser and sfcp_checker; no dependencies.
`default_nettype none

package sfcp_pkg;

    localparam int unsigned ArgSlots = 5;
    localparam int unsigned CfgIdxW  = 3;

    typedef enum logic [2:0] {
        PH_SOF0 = 3'd0,
        PH_SOF1 = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5
    } t_phase;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SOF_FIRST  = 3'd0,
        CFG_SOF_SECOND = 3'd1,
        CFG_CODE_CLEAR = 3'd2,
        CFG_CODE_PIXEL = 3'd3,
        CFG_CODE_LINE  = 3'd4,
        CFG_CODE_PRES  = 3'd5,
        CFG_OUT_EN     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_PIXEL   = 2'd1,
        KIND_LINE    = 2'd2,
        KIND_PRESENT = 2'd3
    } t_kind;

    // payload lengths each command requires
    localparam logic [7:0] LenClear   = 8'd1;
    localparam logic [7:0] LenPixel   = 8'd3;
    localparam logic [7:0] LenLine    = 8'd5;
    localparam logic [7:0] LenPresent = 8'd0;

    // configuration reset values
    localparam logic [7:0] RstSofFirst  = 8'hA5;
    localparam logic [7:0] RstSofSecond = 8'h5A;
    localparam logic [7:0] RstCodeClear = 8'd1;
    localparam logic [7:0] RstCodePixel = 8'd2;
    localparam logic [7:0] RstCodeLine  = 8'd3;
    localparam logic [7:0] RstCodePres  = 8'd4;

    typedef struct packed {
        t_kind                    kind;
        logic [ArgSlots-1:0][7:0] args;
    } t_cmd_result;

endpackage

`default_nettype wire

// ----- rtl/core/sync_framed_command_parser.sv -----
// sync_framed_command_parser: start-marker / length / XOR-checksum frame parser.
// Depends on sfcp_pkg.
//
// Usage:
//   Rx channel: one byte per transaction on i_rx_byte, taken when i_rx_valid
//   is high and o_rx_stall is low. Cmd channel: one decoded command per
//   transaction on o_command_kind / o_arg_*, taken when o_cmd_valid is high
//   and i_cmd_stall is low. Config: i_cfg_wr_en writes i_cfg_wdata into
//   register i_cfg_index (0..6) at the clock edge; write only while idle.
//   Throughput: one byte per cycle while o_rx_stall is low. The frame state
//   machine updates in the cycle a byte is taken; a command enters the output
//   register, or the skid entry when that is full, as its checksum byte is taken.
//   Stall: an output register plus one skid entry sit behind the parser.
//   Bytes keep flowing while a command waits; o_rx_stall rises only when
//   both entries are full.
//   Reset (synchronous, active low): parser returns to hunting the first
//   marker, config registers take their defaults (output disabled), and
//   both output entries are emptied.
`default_nettype none

module sync_framed_command_parser #(
    parameter int unsigned MAX_PAYLOAD = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [sfcp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [7:0]                  i_cfg_wdata,
    input  wire logic                        i_rx_valid,
    output logic                             o_rx_stall,
    input  wire logic [7:0]                  i_rx_byte,
    output logic                             o_cmd_valid,
    input  wire logic                        i_cmd_stall,
    output logic [1:0]                       o_command_kind,
    output logic [7:0]                       o_arg_zero,
    output logic [7:0]                       o_arg_one,
    output logic [7:0]                       o_arg_two,
    output logic [7:0]                       o_arg_three,
    output logic [7:0]                       o_arg_four
);

    localparam int unsigned LenW   = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0]  MaxLen = 8'(MAX_PAYLOAD);
    localparam logic [LenW-1:0] SlotLimit = LenW'(sfcp_pkg::ArgSlots);

    // configuration
    logic [7:0] r_sof_first, r_sof_second;
    logic [7:0] r_code_clear, r_code_pixel, r_code_line, r_code_pres;
    logic       r_out_en;

    // parser state
    sfcp_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_cmd, n_cmd;
    logic [LenW-1:0]  r_len, n_len;
    logic [LenW-1:0]  r_taken, n_taken;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_store [sfcp_pkg::ArgSlots];

    logic             store_we;
    logic [2:0]       store_idx;
    logic [LenW-1:0]  taken_inc;
    logic             rx_take;
    logic             res_valid;
    sfcp_pkg::t_cmd_result res;

    // output register and skid entry
    logic                  r_out_valid, r_skid_valid;
    sfcp_pkg::t_cmd_result r_out, r_skid;
    logic                  out_take;

    assign rx_take  = i_rx_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_cmd_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof_first  <= sfcp_pkg::RstSofFirst;
            r_sof_second <= sfcp_pkg::RstSofSecond;
            r_code_clear <= sfcp_pkg::RstCodeClear;
            r_code_pixel <= sfcp_pkg::RstCodePixel;
            r_code_line  <= sfcp_pkg::RstCodeLine;
            r_code_pres  <= sfcp_pkg::RstCodePres;
            r_out_en     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (sfcp_pkg::t_cfg_idx'(i_cfg_index))
                sfcp_pkg::CFG_SOF_FIRST:  r_sof_first  <= i_cfg_wdata;
                sfcp_pkg::CFG_SOF_SECOND: r_sof_second <= i_cfg_wdata;
                sfcp_pkg::CFG_CODE_CLEAR: r_code_clear <= i_cfg_wdata;
                sfcp_pkg::CFG_CODE_PIXEL: r_code_pixel <= i_cfg_wdata;
                sfcp_pkg::CFG_CODE_LINE:  r_code_line  <= i_cfg_wdata;
                sfcp_pkg::CFG_CODE_PRES:  r_code_pres  <= i_cfg_wdata;
                sfcp_pkg::CFG_OUT_EN:     r_out_en     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfcp_pkg::PH_SOF0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_taken <= '0;
            r_xor   <= '0;
        end else if (rx_take) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_taken <= n_taken;
            r_xor   <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take && store_we) begin
            r_store[store_idx] <= i_rx_byte;
        end
    end

    assign taken_inc = r_taken + LenW'(1);
    assign store_idx = r_taken[2:0];

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_taken   = r_taken;
        n_xor     = r_xor;
        store_we  = 1'b0;
        res_valid = 1'b0;
        res.kind  = sfcp_pkg::KIND_CLEAR;
        res.args  = '0;
        unique case (r_phase)
            sfcp_pkg::PH_SOF0: begin
                if (i_rx_byte == r_sof_first) n_phase = sfcp_pkg::PH_SOF1;
            end
            sfcp_pkg::PH_SOF1: begin
                n_phase = (i_rx_byte == r_sof_second) ? sfcp_pkg::PH_CMD
                                                      : sfcp_pkg::PH_SOF0;
            end
            sfcp_pkg::PH_CMD: begin
                n_cmd   = i_rx_byte;
                n_xor   = i_rx_byte;
                n_phase = sfcp_pkg::PH_LEN;
            end
            sfcp_pkg::PH_LEN: begin
                n_xor = r_xor ^ i_rx_byte;
                if (i_rx_byte > MaxLen) begin
                    n_phase = sfcp_pkg::PH_SOF0;
                end else begin
                    n_len   = i_rx_byte[LenW-1:0];
                    n_taken = '0;
                    n_phase = (i_rx_byte == 8'd0) ? sfcp_pkg::PH_SUM
                                                  : sfcp_pkg::PH_DATA;
                end
            end
            sfcp_pkg::PH_DATA: begin
                store_we = (r_taken < SlotLimit);
                n_xor    = r_xor ^ i_rx_byte;
                n_taken  = taken_inc;
                if (taken_inc >= r_len) n_phase = sfcp_pkg::PH_SUM;
            end
            sfcp_pkg::PH_SUM: begin
                n_phase = sfcp_pkg::PH_SOF0;
                if (i_rx_byte == r_xor && r_out_en) begin
                    // first matching code wins; length must fit that code
                    if (r_cmd == r_code_clear) begin
                        res.kind    = sfcp_pkg::KIND_CLEAR;
                        res.args[0] = r_store[0];
                        res_valid   = ({{(8-LenW){1'b0}}, r_len} == sfcp_pkg::LenClear);
                    end else if (r_cmd == r_code_pixel) begin
                        res.kind    = sfcp_pkg::KIND_PIXEL;
                        res.args[0] = r_store[0];
                        res.args[1] = r_store[1];
                        res.args[2] = r_store[2];
                        res_valid   = ({{(8-LenW){1'b0}}, r_len} == sfcp_pkg::LenPixel);
                    end else if (r_cmd == r_code_line) begin
                        res.kind    = sfcp_pkg::KIND_LINE;
                        res.args[0] = r_store[0];
                        res.args[1] = r_store[1];
                        res.args[2] = r_store[2];
                        res.args[3] = r_store[3];
                        res.args[4] = r_store[4];
                        res_valid   = ({{(8-LenW){1'b0}}, r_len} == sfcp_pkg::LenLine);
                    end else if (r_cmd == r_code_pres) begin
                        res.kind  = sfcp_pkg::KIND_PRESENT;
                        res_valid = ({{(8-LenW){1'b0}}, r_len} == sfcp_pkg::LenPresent);
                    end
                end
            end
            default: n_phase = sfcp_pkg::PH_SOF0;
        endcase
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= rx_take && res_valid;
            end
        end else if (rx_take && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (rx_take && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_rx_stall     = r_skid_valid;
    assign o_cmd_valid    = r_out_valid;
    assign o_command_kind = r_out.kind;
    assign o_arg_zero     = r_out.args[0];
    assign o_arg_one      = r_out.args[1];
    assign o_arg_two      = r_out.args[2];
    assign o_arg_three    = r_out.args[3];
    assign o_arg_four     = r_out.args[4];

endmodule

`default_nettype wire

// ----- rtl/core/sfcp_checker.sv -----
// sfcp_checker: port-level assertions for sync_framed_command_parser.
// Depends on sfcp_pkg; bound to sync_framed_command_parser at the end of this file.
`default_nettype none

module sfcp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_rx_valid,
    input wire logic       o_rx_stall,
    input wire logic       o_cmd_valid,
    input wire logic       i_cmd_stall,
    input wire logic [1:0] o_command_kind,
    input wire logic [7:0] o_arg_zero,
    input wire logic [7:0] o_arg_one,
    input wire logic [7:0] o_arg_two,
    input wire logic [7:0] o_arg_three,
    input wire logic [7:0] o_arg_four
);

    logic rx_take;
    logic [41:0] cmd_bus;

    assign rx_take = i_rx_valid && !o_rx_stall;
    assign cmd_bus = {o_command_kind, o_arg_zero, o_arg_one, o_arg_two,
                      o_arg_three, o_arg_four};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_cmd_valid)
        else $error("command valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && i_cmd_stall |=> o_cmd_valid && $stable(cmd_bus))
        else $error("stalled command changed");

    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_cmd_valid) |-> $past(rx_take))
        else $error("command without a received byte");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_cmd_valid)
        else $error("rx stalled while output empty");

    a_args_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && (o_command_kind == sfcp_pkg::KIND_PRESENT ||
                        o_command_kind == sfcp_pkg::KIND_CLEAR)
        |-> o_arg_one == 8'd0 && o_arg_two == 8'd0 && o_arg_three == 8'd0
            && o_arg_four == 8'd0)
        else $error("unused argument bytes not zero");

endmodule

bind sync_framed_command_parser sfcp_checker u_sfcp_checker (.*);

`default_nettype wire
